### rtl/gdvp_pkg.sv
// gdvp_pkg: word types and fixed widths for the goal distance block
// used by the square root cells and the top level
package gdvp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = 64;
  localparam int unsigned RootW  = 32;
  localparam int unsigned CountW = 7;

  // configuration register indexes
  localparam logic [2:0] REG_GOAL_X       = 3'd0;
  localparam logic [2:0] REG_GOAL_Y       = 3'd1;
  localparam logic [2:0] REG_GOAL_Z       = 3'd2;
  localparam logic [2:0] REG_ACCEPT_LIMIT = 3'd3;
  localparam logic [2:0] REG_FULL_3D_MODE = 3'd4;
  localparam logic [2:0] REG_BODY_COUNT   = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] vel_x;
    logic signed [CoordW-1:0] vel_y;
    logic signed [CoordW-1:0] vel_z;
  } in_word_t;

  typedef struct packed {
    logic [CoordW-1:0] goal_distance;
    logic              goal_reached;
    logic              saturated;
  } out_word_t;

  // what travels from cell to cell: two roots worked in step
  typedef struct packed {
    logic              vld;
    logic [RadW-1:0]   len_rem;
    logic [RootW-1:0]  len_root;
    logic [RadW-1:0]   pen_rem;
    logic [RootW-1:0]  pen_root;
    logic              sat;
    logic              three;
    logic [CountW-1:0] count;
  } cell_t;

endpackage

### rtl/goal_distance_with_velocity_penalty_top.sv
// goal_distance_with_velocity_penalty_top: distance to goal plus velocity penalty
// depends on gdvp_pkg and gdvp_sqrt_cell
//
// Takes one body state word and gives one result word per cycle while the output
// is not stalled. Registers for differences, products and sums feed a chain of 32
// square root cells that each settle one root bit of both the length and the
// penalty root, then a scaling register, then saturation and the compare into the
// output register; the whole pipeline holds while a finished word is stalled. The
// user must write configuration only while no word is in flight; not enforced.
module goal_distance_with_velocity_penalty_top import gdvp_pkg::*; #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned MAX_BODIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned CountClampW = 9;
  localparam int unsigned DistW       = RootW + 1 + CountW;

  logic signed [CoordW-1:0] goal_x;
  logic signed [CoordW-1:0] goal_y;
  logic signed [CoordW-1:0] goal_z;
  logic [CoordW-1:0]        accept_limit;
  logic                     full_3d_mode;
  logic [CountW-1:0]        body_count;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x       <= '0;
      goal_y       <= '0;
      goal_z       <= '0;
      accept_limit <= CoordW'(64'd1 << FRAC_BITS);
      full_3d_mode <= 1'b0;
      body_count   <= CountW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:       goal_x       <= cfg_data;
        REG_GOAL_Y:       goal_y       <= cfg_data;
        REG_GOAL_Z:       goal_z       <= cfg_data;
        REG_ACCEPT_LIMIT: accept_limit <= cfg_data;
        REG_FULL_3D_MODE: full_3d_mode <= cfg_data[0];
        REG_BODY_COUNT:   body_count   <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: differences
  logic                     s1_vld;
  logic signed [CoordW:0]   s1_dx, s1_dy, s1_dz;
  logic signed [CoordW-1:0] s1_vx, s1_vy, s1_vz;
  logic                     s1_three;
  logic [CountW-1:0]        s1_count;
  logic [CountW-1:0]        count_clamped;

  always_comb begin
    if (body_count == '0) begin
      count_clamped = CountW'(1);
    end else if (CountClampW'(body_count) > CountClampW'(MAX_BODIES)) begin
      count_clamped = CountW'(MAX_BODIES);
    end else begin
      count_clamped = body_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx    <= (CoordW+1)'(goal_x) - (CoordW+1)'(in_data.pos_x);
      s1_dy    <= (CoordW+1)'(goal_y) - (CoordW+1)'(in_data.pos_y);
      s1_dz    <= full_3d_mode ? (CoordW+1)'(goal_z) - (CoordW+1)'(in_data.pos_z) : '0;
      s1_vx    <= in_data.vel_x;
      s1_vy    <= in_data.vel_y;
      s1_vz    <= full_3d_mode ? in_data.vel_z : '0;
      s1_three <= full_3d_mode;
      s1_count <= count_clamped;
    end
  end

  // stage 2: squares and dot terms
  logic                       s2_vld;
  logic signed [2*CoordW+1:0] s2_sx, s2_sy, s2_sz;
  logic signed [2*CoordW:0]   s2_px, s2_py, s2_pz;
  logic                       s2_three;
  logic [CountW-1:0]          s2_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sx    <= s1_dx * s1_dx;
      s2_sy    <= s1_dy * s1_dy;
      s2_sz    <= s1_dz * s1_dz;
      s2_px    <= s1_dx * (CoordW+1)'(s1_vx);
      s2_py    <= s1_dy * (CoordW+1)'(s1_vy);
      s2_pz    <= s1_dz * (CoordW+1)'(s1_vz);
      s2_three <= s1_three;
      s2_count <= s1_count;
    end
  end

  // stage 3: sums, radicands and overflow checks
  logic signed [2*CoordW+3:0] sq_sum;
  logic signed [2*CoordW+2:0] dot_sum;
  logic        [2*CoordW+2:0] dot_mag;
  logic                       dot_pos;
  logic                       len_big;
  logic                       pen_big;
  cell_t                      chain [RootW+1];

  assign sq_sum  = (2*CoordW+4)'(s2_sx) + (2*CoordW+4)'(s2_sy) + (2*CoordW+4)'(s2_sz);
  assign dot_sum = (2*CoordW+3)'(s2_px) + (2*CoordW+3)'(s2_py) + (2*CoordW+3)'(s2_pz);
  assign dot_pos = dot_sum > 0;
  assign dot_mag = dot_pos ? '0 : (2*CoordW+3)'(-dot_sum);
  assign len_big = sq_sum[2*CoordW+3:RadW] != '0;
  assign pen_big = dot_mag[2*CoordW+2:RadW] != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (adv) begin
      chain[0].vld      <= s2_vld;
      chain[0].len_rem  <= sq_sum[RadW-1:0];
      chain[0].len_root <= '0;
      chain[0].pen_rem  <= dot_mag[RadW-1:0];
      chain[0].pen_root <= '0;
      chain[0].sat      <= len_big || pen_big;
      chain[0].three    <= s2_three;
      chain[0].count    <= s2_count;
    end
  end

  // root cells, most significant bit first
  for (genvar j = 0; j < RootW; j++) begin : g_cell
    gdvp_sqrt_cell #(
      .BIT(RootW - 1 - j)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .din (chain[j]),
      .dout(chain[j+1])
    );
  end

  // a clipped length or penalty makes both stand in as all ones
  cell_t             tail;
  logic [RootW-1:0]  len_val;
  logic [RootW-1:0]  pen_val;
  logic [RootW:0]    sum_val;
  logic              f1_vld;
  logic [DistW-1:0]  f1_dist;
  logic              f1_sat;

  assign tail    = chain[RootW];
  assign len_val = tail.sat ? '1 : tail.len_root;
  assign pen_val = tail.sat ? '1 : tail.pen_root;
  assign sum_val = (RootW+1)'(len_val) + (RootW+1)'(pen_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else if (adv) begin
      f1_vld <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_dist <= tail.three ? DistW'(sum_val) : DistW'(sum_val) * DistW'(tail.count);
      f1_sat  <= tail.sat;
    end
  end

  // saturate and compare into the output register
  logic             dist_over;
  logic [CoordW-1:0] dist_val;

  assign dist_over = f1_dist[DistW-1:CoordW] != '0;
  assign dist_val  = dist_over ? '1 : f1_dist[CoordW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.goal_distance <= dist_val;
      out_data.goal_reached  <= dist_val < accept_limit;
      out_data.saturated     <= f1_sat || dist_over;
    end
  end

`ifndef SYNTHESIS
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |-> out_data.goal_distance == '1)
    else $error("saturated word without full-scale distance");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input held without a stalled output word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present right after reset");

  a_chain_move: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(chain[RootW].vld) && $stable(f1_vld))
    else $error("pipeline moved while output stalled");
`endif

endmodule

### rtl/gdvp_sqrt_cell.sv
// gdvp_sqrt_cell: one root bit of the length and the penalty square roots
// depends on gdvp_pkg
module gdvp_sqrt_cell import gdvp_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t din,
  output cell_t dout
);

  logic [RadW-1:0] len_trial;
  logic [RadW-1:0] pen_trial;
  logic            len_take;
  logic            pen_take;
  cell_t           dout_next;

  // trial = root * 2^(BIT+1) + 2^(2*BIT)
  assign len_trial = (RadW'(din.len_root) << (BIT + 1)) | (RadW'(1) << (2 * BIT));
  assign pen_trial = (RadW'(din.pen_root) << (BIT + 1)) | (RadW'(1) << (2 * BIT));
  assign len_take  = din.len_rem >= len_trial;
  assign pen_take  = din.pen_rem >= pen_trial;

  always_comb begin
    dout_next = din;
    if (len_take) begin
      dout_next.len_rem  = din.len_rem - len_trial;
      dout_next.len_root = din.len_root | (RootW'(1) << BIT);
    end
    if (pen_take) begin
      dout_next.pen_rem  = din.pen_rem - pen_trial;
      dout_next.pen_root = din.pen_root | (RootW'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

### tb/goal_distance_with_velocity_penalty_top_test.sv
// testbench for goal_distance_with_velocity_penalty_top: random and directed body states
// depends on gdvp_pkg and the top level; predicts each result word and checks in order
module goal_distance_with_velocity_penalty_top_test;
  import gdvp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 20000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  goal_distance_with_velocity_penalty_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic signed [31:0] goal_x_q, goal_y_q, goal_z_q;
  logic [31:0]        limit_q;
  logic               mode3d_q;
  logic [6:0]         bodies_q;

  out_word_t distance_queue[$];
  int        errors = 0;
  int        idle_pct;
  int        watch;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_word_t predict_distance(input in_word_t w);
    logic signed [33:0]  dx, dy, dz, vz;
    logic signed [131:0] sq, dot;
    logic [127:0]        mag;
    logic [63:0]         len, pen;
    logic [71:0]         total;
    logic [6:0]          k;
    logic                sat;
    out_word_t           r;
    dx = 34'(goal_x_q) - 34'(w.pos_x);
    dy = 34'(goal_y_q) - 34'(w.pos_y);
    dz = mode3d_q ? 34'(goal_z_q) - 34'(w.pos_z) : 34'sd0;
    vz = mode3d_q ? 34'(w.vel_z) : 34'sd0;
    sat = 1'b0;
    sq = 132'(dx) * 132'(dx) + 132'(dy) * 132'(dy) + 132'(dz) * 132'(dz);
    if (sq[131:64] != 0) begin
      sat = 1'b1;
      len = 64'hFFFF_FFFF;
    end else begin
      len = int_sqrt(sq[63:0]);
    end
    dot = 132'(dx) * 132'(w.vel_x) + 132'(dy) * 132'(w.vel_y) + 132'(dz) * 132'(vz);
    if (dot > 0) begin
      pen = 0;
    end else begin
      mag = 128'(-dot);
      if (mag[127:64] != 0) begin
        sat = 1'b1;
        pen = 64'hFFFF_FFFF;
      end else begin
        pen = int_sqrt(mag[63:0]);
      end
    end
    total = 72'(len) + 72'(pen);
    if (!mode3d_q) begin
      k = bodies_q;
      if (k == 0) k = 1;
      if (k > 64) k = 64;
      total = total * 72'(k);
    end
    if (total > 72'hFFFF_FFFF) begin
      total = 72'hFFFF_FFFF;
      sat = 1'b1;
    end
    r.goal_distance = total[31:0];
    r.goal_reached = total[31:0] < limit_q;
    r.saturated = sat;
    return r;
  endfunction

  // result checker and idle-cycle watchdog
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      watch <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (distance_queue.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          errors++;
        end else begin
          want = distance_queue.pop_front();
          if (out_data.goal_distance !== want.goal_distance) begin
            $error("goal_distance expected %h actual %h", want.goal_distance,
                   out_data.goal_distance);
            errors++;
          end
          if (out_data.goal_reached !== want.goal_reached) begin
            $error("goal_reached expected %b actual %b", want.goal_reached,
                   out_data.goal_reached);
            errors++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated expected %b actual %b", want.saturated, out_data.saturated);
            errors++;
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WatchLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_GOAL_X:       goal_x_q = v;
      REG_GOAL_Y:       goal_y_q = v;
      REG_GOAL_Z:       goal_z_q = v;
      REG_ACCEPT_LIMIT: limit_q = v;
      REG_FULL_3D_MODE: mode3d_q = v[0];
      REG_BODY_COUNT:   bodies_q = v[6:0];
      default: ;
    endcase
  endtask

  // valid stays high after the accepting edge; the next idle cycle or drain drops it
  task automatic send_word(input in_word_t w);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    distance_queue = {distance_queue, predict_distance(w)};
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int scale);
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2 * scale)) - scale);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(512)) - 256) << 16;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int s;
    s = $urandom_range(1) ? 32'h0080_0000 : 32'h0000_0400;
    w.pos_x = rand_coord(s);
    w.pos_y = rand_coord(s);
    w.pos_z = rand_coord(s);
    w.vel_x = rand_coord(s);
    w.vel_y = rand_coord(s);
    w.vel_z = rand_coord(s);
    return w;
  endfunction

  task automatic test_directed;
    in_word_t w;
    logic [31:0] ext [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    foreach (ext[i]) begin
      w = '{ext[i], ext[i], ext[i], ext[3 - i], ext[3 - i], ext[3 - i]};
      send_word(w);
    end
    // exactly at goal, pointing away, pointing toward it
    w = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0};
    send_word(w);
    w = '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0};
    send_word(w);
    w = '{32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0};
    send_word(w);
    w = '{32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    send_word(w);
    drain();
  endtask

  task automatic test_config_extremes;
    in_word_t w;
    write_reg(REG_GOAL_X, 32'h7FFF_FFFF);
    write_reg(REG_GOAL_Y, 32'h8000_0000);
    write_reg(REG_GOAL_Z, 32'h7FFF_FFFF);
    write_reg(REG_ACCEPT_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_FULL_3D_MODE, 32'd1);
    write_reg(REG_BODY_COUNT, 32'd64);
    w = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_word(w);
    w = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_word(w);
    drain();
    // planar with zero and oversize body counts
    write_reg(REG_FULL_3D_MODE, 32'd0);
    write_reg(REG_GOAL_X, 32'h0);
    write_reg(REG_GOAL_Y, 32'h0);
    write_reg(REG_ACCEPT_LIMIT, 32'h0);
    write_reg(REG_BODY_COUNT, 32'd0);
    send_word('{32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0});
    drain();
    write_reg(REG_BODY_COUNT, 32'd127);
    send_word('{32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0});
    send_word('{32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    drain();
  endtask

  task automatic test_random(input int n);
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_GOAL_X, rand_coord(32'h0080_0000));
      write_reg(REG_GOAL_Y, rand_coord(32'h0080_0000));
      write_reg(REG_GOAL_Z, rand_coord(32'h0080_0000));
      write_reg(REG_ACCEPT_LIMIT, $urandom_range(1) ? $urandom : $urandom_range(32'h0100_0000));
      write_reg(REG_FULL_3D_MODE, p % 2);
      write_reg(REG_BODY_COUNT, (p == 2) ? 1 : (p == 4) ? 64 : $urandom_range(127));
      // long run with no idling in one phase
      idle_pct = (p == 3) ? 0 : 33;
      for (int i = 0; i < n / 8; i++) send_word(rand_word());
      drain();
    end
  endtask

  initial begin
    idle_pct = 33;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_GOAL_X;
    cfg_data <= '0;
    goal_x_q = 0;
    goal_y_q = 0;
    goal_z_q = 0;
    limit_q = 32'h0001_0000;
    mode3d_q = 1'b0;
    bodies_q = 7'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random(1600);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
